[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files (used by lpu_ctrl).
// Needs signals clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define LPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define LPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[hw/rtl/lpu_pkg.sv]
// Types, constants, fixed-point helpers and micro-program for the undistort block.
// No dependencies.
package lpu_pkg;
	localparam int FRAC_BITS = 24;
	localparam int QW = 32;
	localparam int WW = 66;
	localparam int LIM_W = 41;
	localparam int DVW = QW + FRAC_BITS;
	localparam int CNT_W = $clog2(DVW);
	localparam int PC_W = 7;
	localparam int RAM_D = 32;
	localparam int RAM_AW = $clog2(RAM_D);

	localparam logic [2:0] CFG_K1 = 3'd0;
	localparam logic [2:0] CFG_K2 = 3'd1;
	localparam logic [2:0] CFG_P1 = 3'd2;
	localparam logic [2:0] CFG_P2 = 3'd3;
	localparam logic [2:0] CFG_LIM = 3'd4;
	localparam logic [2:0] CFG_ITER = 3'd5;

	localparam logic [3:0] OP_MUL = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_SCL2 = 4'd3;
	localparam logic [3:0] OP_SCL4 = 4'd4;
	localparam logic [3:0] OP_SCL6 = 4'd5;
	localparam logic [3:0] OP_ASET = 4'd6;
	localparam logic [3:0] OP_AADD = 4'd7;
	localparam logic [3:0] OP_ASUB = 4'd8;
	localparam logic [3:0] OP_NAR = 4'd9;
	localparam logic [3:0] OP_DET = 4'd10;
	localparam logic [3:0] OP_CONV = 4'd11;
	localparam logic [3:0] OP_DIV = 4'd12;

	// operand codes: scratch memory below 32, fixed registers from 32 up
	localparam logic [5:0] R_X2 = 6'd0;
	localparam logic [5:0] R_Y2 = 6'd1;
	localparam logic [5:0] R_XY = 6'd2;
	localparam logic [5:0] R_R2 = 6'd3;
	localparam logic [5:0] R_RAD = 6'd4;
	localparam logic [5:0] R_T = 6'd5;
	localparam logic [5:0] R_T2 = 6'd6;
	localparam logic [5:0] R_OFFX = 6'd7;
	localparam logic [5:0] R_OFFY = 6'd8;
	localparam logic [5:0] R_KR2 = 6'd9;
	localparam logic [5:0] R_A = 6'd10;
	localparam logic [5:0] R_B = 6'd11;
	localparam logic [5:0] R_D = 6'd12;
	localparam logic [5:0] R_EX = 6'd13;
	localparam logic [5:0] R_EY = 6'd14;
	localparam logic [5:0] R_NX = 6'd15;
	localparam logic [5:0] R_NY = 6'd16;
	localparam logic [5:0] R_DET = 6'd17;
	localparam logic [5:0] C_ONE = 6'd32;
	localparam logic [5:0] C_K1 = 6'd33;
	localparam logic [5:0] C_K2 = 6'd34;
	localparam logic [5:0] C_P1 = 6'd35;
	localparam logic [5:0] C_P2 = 6'd36;
	localparam logic [5:0] C_DX = 6'd37;
	localparam logic [5:0] C_DY = 6'd38;
	localparam logic [5:0] C_X = 6'd39;
	localparam logic [5:0] C_Y = 6'd40;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_OPS = 2'd1;
	localparam logic [1:0] PH_EXE = 2'd2;
	localparam logic [1:0] PH_WB = 2'd3;

	localparam logic [PC_W-1:0] PC_CHKDET = PC_W'(72);
	localparam logic [PC_W-1:0] PC_LAST = PC_W'(81);

	typedef struct packed {
		logic [3:0] op;
		logic [5:0] a;
		logic [5:0] b;
		logic [5:0] dst;
	} uop_t;

	typedef struct packed {
		logic [1:0] ph;
		logic load;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic det_zero;
		logic conv;
	} stat_t;

	localparam logic signed [WW-1:0] SMAX = WW'(64'sd2147483647);
	localparam logic signed [WW-1:0] SMIN = -WW'(64'sd2147483648);
	localparam logic signed [WW-1:0] RND = WW'(1) << (FRAC_BITS - 1);

	function automatic logic [QW-1:0] sat(input logic signed [WW-1:0] v);
		logic [QW-1:0] r;
		if (v > SMAX) r = SMAX[QW-1:0];
		else if (v < SMIN) r = SMIN[QW-1:0];
		else r = v[QW-1:0];
		return r;
	endfunction

	function automatic logic [QW-1:0] narrow(input logic signed [WW-1:0] w);
		logic signed [WW-1:0] t;
		t = (w + RND) >>> FRAC_BITS;
		return sat(t);
	endfunction

	function automatic uop_t u(input logic [3:0] op, input logic [5:0] a,
		input logic [5:0] b, input logic [5:0] d);
		uop_t r;
		r.op = op; r.a = a; r.b = b; r.dst = d;
		return r;
	endfunction

	function automatic uop_t rom(input logic [PC_W-1:0] pc);
		uop_t r;
		case (pc)
			7'd0: r = u(OP_MUL, C_X, C_X, R_X2);
			7'd1: r = u(OP_MUL, C_Y, C_Y, R_Y2);
			7'd2: r = u(OP_MUL, C_X, C_Y, R_XY);
			7'd3: r = u(OP_ADD, R_X2, R_Y2, R_R2);
			7'd4: r = u(OP_MUL, C_K1, R_R2, R_T);
			7'd5: r = u(OP_MUL, R_R2, R_R2, R_T2);
			7'd6: r = u(OP_MUL, C_K2, R_T2, R_T2);
			7'd7: r = u(OP_ADD, R_T, R_T2, R_RAD);
			7'd8: r = u(OP_MUL, C_X, R_RAD, R_T);
			7'd9: r = u(OP_MUL, C_P1, R_XY, R_T2);
			7'd10: r = u(OP_SCL2, R_T2, R_T2, R_T2);
			7'd11: r = u(OP_ADD, R_T, R_T2, R_T);
			7'd12: r = u(OP_SCL2, R_X2, R_X2, R_T2);
			7'd13: r = u(OP_ADD, R_R2, R_T2, R_T2);
			7'd14: r = u(OP_MUL, C_P2, R_T2, R_T2);
			7'd15: r = u(OP_ADD, R_T, R_T2, R_OFFX);
			7'd16: r = u(OP_MUL, C_Y, R_RAD, R_T);
			7'd17: r = u(OP_MUL, C_P2, R_XY, R_T2);
			7'd18: r = u(OP_SCL2, R_T2, R_T2, R_T2);
			7'd19: r = u(OP_ADD, R_T, R_T2, R_T);
			7'd20: r = u(OP_SCL2, R_Y2, R_Y2, R_T2);
			7'd21: r = u(OP_ADD, R_R2, R_T2, R_T2);
			7'd22: r = u(OP_MUL, C_P1, R_T2, R_T2);
			7'd23: r = u(OP_ADD, R_T, R_T2, R_OFFY);
			7'd24: r = u(OP_MUL, C_K2, R_R2, R_KR2);
			7'd25: r = u(OP_ADD, C_ONE, R_RAD, R_A);
			7'd26: r = u(OP_MUL, C_K1, R_X2, R_T);
			7'd27: r = u(OP_SCL2, R_T, R_T, R_T);
			7'd28: r = u(OP_ADD, R_A, R_T, R_A);
			7'd29: r = u(OP_MUL, R_KR2, R_X2, R_T);
			7'd30: r = u(OP_SCL4, R_T, R_T, R_T);
			7'd31: r = u(OP_ADD, R_A, R_T, R_A);
			7'd32: r = u(OP_MUL, C_P1, C_Y, R_T);
			7'd33: r = u(OP_SCL2, R_T, R_T, R_T);
			7'd34: r = u(OP_ADD, R_A, R_T, R_A);
			7'd35: r = u(OP_MUL, C_P2, C_X, R_T);
			7'd36: r = u(OP_SCL6, R_T, R_T, R_T);
			7'd37: r = u(OP_ADD, R_A, R_T, R_A);
			7'd38: r = u(OP_MUL, C_K1, R_XY, R_B);
			7'd39: r = u(OP_SCL2, R_B, R_B, R_B);
			7'd40: r = u(OP_MUL, R_KR2, R_XY, R_T);
			7'd41: r = u(OP_SCL4, R_T, R_T, R_T);
			7'd42: r = u(OP_ADD, R_B, R_T, R_B);
			7'd43: r = u(OP_MUL, C_P1, C_X, R_T);
			7'd44: r = u(OP_SCL2, R_T, R_T, R_T);
			7'd45: r = u(OP_ADD, R_B, R_T, R_B);
			7'd46: r = u(OP_MUL, C_P2, C_Y, R_T);
			7'd47: r = u(OP_SCL2, R_T, R_T, R_T);
			7'd48: r = u(OP_ADD, R_B, R_T, R_B);
			7'd49: r = u(OP_ADD, C_ONE, R_RAD, R_D);
			7'd50: r = u(OP_MUL, C_K1, R_Y2, R_T);
			7'd51: r = u(OP_SCL2, R_T, R_T, R_T);
			7'd52: r = u(OP_ADD, R_D, R_T, R_D);
			7'd53: r = u(OP_MUL, R_KR2, R_Y2, R_T);
			7'd54: r = u(OP_SCL4, R_T, R_T, R_T);
			7'd55: r = u(OP_ADD, R_D, R_T, R_D);
			7'd56: r = u(OP_MUL, C_P1, C_Y, R_T);
			7'd57: r = u(OP_SCL6, R_T, R_T, R_T);
			7'd58: r = u(OP_ADD, R_D, R_T, R_D);
			7'd59: r = u(OP_MUL, C_P2, C_X, R_T);
			7'd60: r = u(OP_SCL2, R_T, R_T, R_T);
			7'd61: r = u(OP_ADD, R_D, R_T, R_D);
			7'd62: r = u(OP_SUB, C_DX, C_X, R_EX);
			7'd63: r = u(OP_SUB, R_EX, R_OFFX, R_EX);
			7'd64: r = u(OP_SUB, C_DY, C_Y, R_EY);
			7'd65: r = u(OP_SUB, R_EY, R_OFFY, R_EY);
			7'd66: r = u(OP_ASET, R_EX, R_EX, R_T);
			7'd67: r = u(OP_AADD, R_EY, R_EY, R_T);
			7'd68: r = u(OP_CONV, R_T, R_T, R_T);
			7'd69: r = u(OP_ASET, R_A, R_D, R_T);
			7'd70: r = u(OP_ASUB, R_B, R_B, R_T);
			7'd71: r = u(OP_DET, R_T, R_T, R_DET);
			7'd72: r = u(OP_ASET, R_D, R_EX, R_T);
			7'd73: r = u(OP_ASUB, R_B, R_EY, R_T);
			7'd74: r = u(OP_NAR, R_T, R_T, R_NX);
			7'd75: r = u(OP_ASET, R_A, R_EY, R_T);
			7'd76: r = u(OP_ASUB, R_B, R_EX, R_T);
			7'd77: r = u(OP_NAR, R_T, R_T, R_NY);
			7'd78: r = u(OP_DIV, R_NX, R_DET, R_T);
			7'd79: r = u(OP_ADD, C_X, R_T, C_X);
			7'd80: r = u(OP_DIV, R_NY, R_DET, R_T);
			7'd81: r = u(OP_ADD, C_Y, R_T, C_Y);
			default: r = u(OP_CONV, R_T, R_T, R_T);
		endcase
		return r;
	endfunction
endpackage

[hw/rtl/lpu_ram.sv]
// Generic scratch RAM: one write port, two registered read ports.
// No dependencies.
module lpu_ram #(
	parameter int W = 32,
	parameter int D = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(D)-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic [$clog2(D)-1:0] raddr0,
	input logic [$clog2(D)-1:0] raddr1,
	output logic [W-1:0] rdata0,
	output logic [W-1:0] rdata1
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end
endmodule

[hw/rtl/lpu_div.sv]
// Restoring divider: (num * 2^FRAC_BITS) / den, truncated toward zero, saturated.
// Depends on lpu_pkg.
module lpu_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [lpu_pkg::QW-1:0] num,
	input logic [lpu_pkg::QW-1:0] den,
	output logic done,
	output logic [lpu_pkg::QW-1:0] quo
);
	import lpu_pkg::*;

	logic busy_q, done_q, neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QW-1:0] rem_q, den_q;
	logic [DVW-1:0] dq_q;
	logic [QW+1:0] trial;

	assign trial = {1'b0, rem_q, dq_q[DVW-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[QW-1] ^ den[QW-1];
			dq_q <= {(num[QW-1] ? (~num + 1'b1) : num), {FRAC_BITS{1'b0}}};
			den_q <= den[QW-1] ? (~den + 1'b1) : den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[QW+1]) begin
				rem_q <= trial[QW-1:0];
				dq_q <= {dq_q[DVW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[QW-2:0], dq_q[DVW-1]};
				dq_q <= {dq_q[DVW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (!neg_q) begin
			quo = (|dq_q[DVW-1:QW-1]) ? {1'b0, {(QW-1){1'b1}}} : dq_q[QW-1:0];
		end else if ((|dq_q[DVW-1:QW]) || (dq_q[QW-1] && (|dq_q[QW-2:0]))) begin
			quo = {1'b1, {(QW-1){1'b0}}};
		end else begin
			quo = ~dq_q[QW-1:0] + 1'b1;
		end
	end

	assign done = done_q;
endmodule

[hw/rtl/lpu_dp.sv]
// Datapath: coefficient registers, scratch RAM, shared multiplier, accumulator, divider.
// Depends on lpu_pkg, lpu_ram, lpu_div.
module lpu_dp (
	input logic clk,
	input logic arst_n,
	input lpu_pkg::cmd_t cmd,
	output lpu_pkg::stat_t stat,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [lpu_pkg::LIM_W-1:0] cfg_data,
	input logic [lpu_pkg::QW-1:0] dist_x,
	input logic [lpu_pkg::QW-1:0] dist_y,
	output logic [lpu_pkg::QW-1:0] undist_x,
	output logic [lpu_pkg::QW-1:0] undist_y
);
	import lpu_pkg::*;

	logic [QW-1:0] k1_q, k2_q, p1_q, p2_q, dx_q, dy_q, x_q, y_q;
	logic [LIM_W-1:0] lim_q;
	logic [QW-1:0] rd0, rd1, opa, opb, a_q, b_q, res, wdata, quo;
	logic signed [2*QW-1:0] p_q;
	logic signed [WW-1:0] acc_q, pw, aw, bw;
	logic conv_q, detz_q, div_done, exe, wr, ram_we;

	function automatic logic [QW-1:0] fixed_reg(input logic [5:0] c,
		input logic [QW-1:0] k1, input logic [QW-1:0] k2, input logic [QW-1:0] p1,
		input logic [QW-1:0] p2, input logic [QW-1:0] dx, input logic [QW-1:0] dy,
		input logic [QW-1:0] x, input logic [QW-1:0] y);
		logic [QW-1:0] r;
		case (c)
			C_ONE: r = QW'(1) << FRAC_BITS;
			C_K1: r = k1;
			C_K2: r = k2;
			C_P1: r = p1;
			C_P2: r = p2;
			C_DX: r = dx;
			C_DY: r = dy;
			C_X: r = x;
			C_Y: r = y;
			default: r = '0;
		endcase
		return r;
	endfunction

	lpu_ram #(.W(QW), .D(RAM_D)) u_ram (
		.clk(clk), .we(ram_we), .waddr(cmd.uop.dst[RAM_AW-1:0]), .wdata(wdata),
		.raddr0(cmd.uop.a[RAM_AW-1:0]), .raddr1(cmd.uop.b[RAM_AW-1:0]),
		.rdata0(rd0), .rdata1(rd1)
	);

	lpu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(exe && cmd.uop.op == OP_DIV),
		.num(a_q), .den(b_q), .done(div_done), .quo(quo)
	);

	assign opa = cmd.uop.a[5] ?
		fixed_reg(cmd.uop.a, k1_q, k2_q, p1_q, p2_q, dx_q, dy_q, x_q, y_q) : rd0;
	assign opb = cmd.uop.b[5] ?
		fixed_reg(cmd.uop.b, k1_q, k2_q, p1_q, p2_q, dx_q, dy_q, x_q, y_q) : rd1;

	assign pw = WW'(p_q);
	assign aw = WW'($signed(a_q));
	assign bw = WW'($signed(b_q));
	assign exe = cmd.ph == PH_EXE;

	always_comb begin
		wr = exe;
		case (cmd.uop.op)
			OP_MUL: res = narrow(pw);
			OP_ADD: res = sat(aw + bw);
			OP_SUB: res = sat(aw - bw);
			OP_SCL2: res = sat(aw <<< 1);
			OP_SCL4: res = sat(aw <<< 2);
			OP_SCL6: res = sat((aw <<< 2) + (aw <<< 1));
			OP_NAR, OP_DET: res = narrow(acc_q);
			default: begin
				res = '0;
				wr = 1'b0;
			end
		endcase
		if (cmd.ph == PH_WB) wr = 1'b1;
		wdata = (cmd.ph == PH_WB) ? quo : res;
	end

	assign ram_we = wr && !cmd.uop.dst[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
			lim_q <= LIM_W'(281474977);
			conv_q <= 1'b0;
			detz_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_K1: k1_q <= cfg_data[QW-1:0];
					CFG_K2: k2_q <= cfg_data[QW-1:0];
					CFG_P1: p1_q <= cfg_data[QW-1:0];
					CFG_P2: p2_q <= cfg_data[QW-1:0];
					CFG_LIM: lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (exe && cmd.uop.op == OP_CONV) conv_q <= acc_q <= $signed(WW'(lim_q));
			if (exe && cmd.uop.op == OP_DET) detz_q <= (res == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= dist_x;
			dy_q <= dist_y;
			x_q <= dist_x;
			y_q <= dist_y;
		end else if (wr && cmd.uop.dst == C_X) begin
			x_q <= wdata;
		end else if (wr && cmd.uop.dst == C_Y) begin
			y_q <= wdata;
		end
		if (cmd.ph == PH_OPS) begin
			a_q <= opa;
			b_q <= opb;
			p_q <= $signed(opa) * $signed(opb);
		end
		if (exe) begin
			case (cmd.uop.op)
				OP_ASET: acc_q <= pw;
				OP_AADD: acc_q <= acc_q + pw;
				OP_ASUB: acc_q <= acc_q - pw;
				default: ;
			endcase
		end
	end

	assign stat.div_done = div_done;
	assign stat.det_zero = detz_q;
	assign stat.conv = conv_q;
	assign undist_x = x_q;
	assign undist_y = y_q;
endmodule

[hw/rtl/lpu_ctrl.sv]
// Controller: steps the micro-program, counts iterations, decides when to stop.
// Depends on lpu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lpu_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	output logic singular,
	output logic [7:0] steps_used,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data,
	input lpu_pkg::stat_t stat,
	output lpu_pkg::cmd_t cmd
);
	import lpu_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_OPS = 3'd2;
	localparam logic [2:0] S_EXE = 3'd3;
	localparam logic [2:0] S_DWAIT = 3'd4;
	localparam logic [2:0] S_DWB = 3'd5;
	localparam logic [2:0] S_FIN = 3'd6;

	logic [2:0] state_q;
	logic [PC_W-1:0] pc_q;
	logic [7:0] steps_q, iter_q, lim;
	logic sing_q, step_end, accept;
	uop_t uop;

	assign uop = rom(pc_q);
	assign lim = (iter_q == '0) ? 8'd1 : iter_q;
	assign accept = start && (state_q == S_IDLE);
	assign step_end = (state_q == S_DWB) || (state_q == S_EXE && uop.op != OP_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			steps_q <= '0;
			iter_q <= 8'd20;
			sing_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_ITER) iter_q <= cfg_data;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD;
						pc_q <= '0;
						steps_q <= 8'd1;
						sing_q <= 1'b0;
					end
				end
				S_RD: begin
					if (pc_q == PC_CHKDET && stat.det_zero) begin
						sing_q <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_OPS;
					end
				end
				S_OPS: state_q <= S_EXE;
				S_EXE: if (uop.op == OP_DIV) state_q <= S_DWAIT;
				S_DWAIT: if (stat.div_done) state_q <= S_DWB;
				S_FIN: state_q <= S_IDLE;
				default: ;
			endcase
			if (step_end) begin
				if (pc_q != PC_LAST) begin
					pc_q <= pc_q + 1'b1;
					state_q <= S_RD;
				end else if (stat.conv || steps_q == lim) begin
					state_q <= S_FIN;
				end else begin
					pc_q <= '0;
					steps_q <= steps_q + 1'b1;
					state_q <= S_RD;
				end
			end
		end
	end

	always_comb begin
		cmd.uop = uop;
		cmd.load = accept;
		case (state_q)
			S_OPS: cmd.ph = PH_OPS;
			S_EXE: cmd.ph = PH_EXE;
			S_DWB: cmd.ph = PH_WB;
			default: cmd.ph = PH_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_FIN;
	assign singular = sing_q;
	assign steps_used = steps_q;

	`LPU_ASSERT_NXT(a_accept_busy, accept, busy && !done)
	`LPU_ASSERT_NXT(a_done_idle, done, !busy)
	`LPU_ASSERT_IMP(a_steps_range, done, steps_used != 8'd0 && steps_used <= lim)
	`LPU_ASSERT_IMP(a_wait_div, state_q == S_DWAIT, pc_q == PC_W'(78) || pc_q == PC_W'(80))
endmodule

[hw/rtl/lens_point_undistort_gauss_newton.sv]
// Top level of the Gauss-Newton lens point undistort block.
// Depends on lpu_pkg, lpu_ctrl, lpu_dp (and through it lpu_ram, lpu_div).
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start, busy        | dist_x, dist_y
//  result   | done (one cycle)   | undist_x, undist_y, converged, singular,
//           |                    | steps_used
//  config   | cfg_we             | cfg_index, cfg_data
//
// Each micro-step of an iteration passes through read, operand and execute states on the
// shared multiplier and scratch RAM; each of the two divisions is issued through those
// states, then waits for the divider and writes the quotient back. A run stops early at a
// zero determinant; the next item can be accepted once the controller is back in idle.
// One item at a time: busy stays high from the cycle after accept through the done cycle.
// Reset returns the controller to idle and the config and status registers to defaults.
// The result receiver cannot stall.
module lens_point_undistort_gauss_newton (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] dist_x,
	input logic [31:0] dist_y,
	output logic done,
	output logic [31:0] undist_x,
	output logic [31:0] undist_y,
	output logic converged,
	output logic singular,
	output logic [7:0] steps_used,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [lpu_pkg::LIM_W-1:0] cfg_data
);
	import lpu_pkg::*;

	cmd_t cmd;
	stat_t stat;

	lpu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.singular(singular), .steps_used(steps_used), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data[7:0]), .stat(stat), .cmd(cmd)
	);

	lpu_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .dist_x(dist_x), .dist_y(dist_y),
		.undist_x(undist_x), .undist_y(undist_y)
	);

	assign converged = stat.conv;
endmodule
